// File: hw/rtl/swf_pkg.sv
// ----------------------------------------------------------------------------
// Sigma window filter package
// Shared constants, register indexes and types of the sigma window filter.
// ----------------------------------------------------------------------------
package swf_pkg;

  localparam int unsigned MAX_WINDOW = 7;
  localparam int unsigned MAX_LINE   = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // The history store is a power of two deep; it covers the furthest reach
  // of the window in both directions, so indexing modulo its depth is exact.
  localparam int unsigned HIST_AW    = 13;
  localparam int unsigned HIST_DEPTH = 1 << HIST_AW;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned POS_W  = 21;
  localparam int unsigned SUM_W  = 14;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 11;

  typedef enum logic [CFG_AW-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_SIGMA_LIMIT  = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_e;

  localparam logic [2:0]       RST_WINDOW_SIZE  = 3'd3;
  localparam logic [PIX_W-1:0] RST_SIGMA_LIMIT  = 8'd255;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;

endpackage

// File: hw/rtl/swf_in_if.sv
// ----------------------------------------------------------------------------
// Sigma window filter input channel
// Valid/ready channel carrying a pixel or a flush tick.
// ----------------------------------------------------------------------------
interface swf_in_if;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [swf_pkg::PIX_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

// File: hw/rtl/swf_out_if.sv
// ----------------------------------------------------------------------------
// Sigma window filter output channel
// Valid/ready channel carrying one filtered pixel.
// ----------------------------------------------------------------------------
interface swf_out_if;
  logic                    valid;
  logic                    ready;
  logic [swf_pkg::PIX_W-1:0] filtered;
  logic                    frame_end;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

// File: hw/rtl/swf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/sigma_window_filter_unit.sv
// ----------------------------------------------------------------------------
// Sigma window filter
// Sigma-gated window averaging over one 8-bit raster channel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on in_s, one beat per pixel (kind 0), and
// flush beats (kind 1) drain the outputs still pending at the frame's end.
// Each input beat gives at most one output beat on out_m, the filtered value
// of the next centre pixel together with a frame_end flag on the last pixel.
// An output appears once enough lines have arrived to cover the window.
// The block handles one beat at a time: a beat that gives no output is taken
// straight from idle, one that gives an output first reads the centre, then
// scans the window and runs the division before the next beat is accepted.
// The scan reads one neighbour a cycle from the single read port of the
// line history memory, and one shared compare/add and subtract unit serves
// both the scan and the restoring division.
// A finished result sits in an output register, so the next input beat is
// taken while it waits; a stalled receiver only holds the block once a
// second result is ready. Reset returns all positions to the frame start and
// the registers to their defaults; the history memory needs no clearing,
// as only pixels of the current frame are ever read. Any register write
// restarts the frame.
// ----------------------------------------------------------------------------
module sigma_window_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swf_pkg::CFG_AW-1:0]     cfg_idx_i,
  input  logic [swf_pkg::CFG_DW-1:0]     cfg_data_i,
  swf_in_if.sink                         in_s,
  swf_out_if.source                      out_m
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CRD  = 7'b0000010,
    ST_CLAT = 7'b0000100,
    ST_SCAN = 7'b0001000,
    ST_TAIL = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  localparam int unsigned AW = swf_pkg::HIST_AW;
  localparam int unsigned PW = swf_pkg::POS_W;
  localparam int unsigned DW = swf_pkg::DIM_W;

  // Configuration registers.
  logic [2:0]                  win_q;
  logic [swf_pkg::PIX_W-1:0]   sigma_q;
  logic [DW-1:0]               fw_q, fh_q;

  state_e state_q, state_d;

  logic [PW-1:0] in_cnt_q, in_cnt_d;
  logic [PW-1:0] out_pos_q, out_pos_d;
  logic [DW-1:0] out_row_q, out_row_d, out_col_q, out_col_d;

  logic [AW-1:0]             addr_q, addr_d;
  logic [2:0]                ci_q, ci_d, cj_q, cj_d;
  logic                      pend_q, pend_d;
  logic [swf_pkg::PIX_W-1:0] centre_q, centre_d;
  logic [swf_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [swf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [swf_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [3:0]                step_q, step_d;

  logic                      ovalid_q, ovalid_d;
  logic [swf_pkg::PIX_W-1:0] ofilt_q, ofilt_d;
  logic                      oend_q, oend_d;

  // Effective frame geometry after the clamps on zero and oversize values.
  logic [DW-1:0] eff_w, eff_h;
  logic [1:0]    half;
  logic [2:0]    side;
  logic [PW-1:0] total, lag, need_raw, need, cnt_next;
  logic          in_acc, wr_en, emit;

  always_comb begin
    eff_w = fw_q;
    if (fw_q == '0) eff_w = DW'(1);
    if (fw_q > DW'(swf_pkg::MAX_LINE)) eff_w = DW'(swf_pkg::MAX_LINE);
    eff_h = fh_q;
    if (fh_q == '0) eff_h = DW'(1);
    if (fh_q > DW'(swf_pkg::MAX_HEIGHT)) eff_h = DW'(swf_pkg::MAX_HEIGHT);
  end

  assign half     = win_q[2:1];
  assign side     = {half, 1'b1};
  assign total    = PW'(eff_w) * PW'(eff_h);
  assign lag      = PW'(half) * PW'(eff_w) + PW'(half);
  assign need_raw = out_pos_q + lag + PW'(1);
  assign need     = (need_raw > total) ? total : need_raw;

  assign in_s.ready = (state_q == ST_IDLE);
  assign in_acc     = in_s.valid && in_s.ready;
  assign wr_en      = in_acc && !in_s.kind && (in_cnt_q < total);
  assign cnt_next   = wr_en ? in_cnt_q + PW'(1) : in_cnt_q;
  assign emit       = (out_pos_q < total) && (cnt_next >= need);

  // Neighbour position of the current window cell; cells off the frame
  // are skipped.
  logic signed [DW+1:0] nr, nc;
  logic                 cell_ok, last_col, last_cell;

  always_comb begin
    nr = $signed({2'b00, out_row_q}) - $signed({{DW{1'b0}}, half})
         + $signed({{(DW-1){1'b0}}, ci_q});
    nc = $signed({2'b00, out_col_q}) - $signed({{DW{1'b0}}, half})
         + $signed({{(DW-1){1'b0}}, cj_q});
    cell_ok = (nr >= 0) && (nr < $signed({2'b00, eff_h}))
           && (nc >= 0) && (nc < $signed({2'b00, eff_w}));
    last_col  = (cj_q == side - 3'd1);
    last_cell = last_col && (ci_q == side - 3'd1);
  end

  // History memory.
  logic [AW-1:0]             raddr;
  logic [swf_pkg::PIX_W-1:0] rdata;

  assign raddr = (state_q == ST_CRD) ? out_pos_q[AW-1:0] : addr_q;

  swf_ram #(
    .WIDTH (swf_pkg::PIX_W),
    .DEPTH (swf_pkg::HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (in_cnt_q[AW-1:0]),
    .wdata_i (in_s.sample),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared arithmetic: the absolute difference test during the scan and the
  // trial subtraction during the division.
  logic [swf_pkg::PIX_W-1:0]   diff;
  logic [swf_pkg::CNT_W:0]     trial, trial_sub;
  logic                        trial_ge;

  assign diff      = (rdata > centre_q) ? rdata - centre_q : centre_q - rdata;
  assign trial     = {rem_q, sum_q[swf_pkg::SUM_W-1]};
  assign trial_ge  = trial >= {1'b0, cnt_q};
  assign trial_sub = trial - {1'b0, cnt_q};

  logic out_free, pos_last;
  assign out_free = !ovalid_q || out_m.ready;
  assign pos_last = (out_pos_q + PW'(1)) == total;

  always_comb begin
    state_d   = state_q;
    in_cnt_d  = in_cnt_q;
    out_pos_d = out_pos_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    addr_d    = addr_q;
    ci_d      = ci_q;
    cj_d      = cj_q;
    pend_d    = 1'b0;
    centre_d  = centre_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    step_d    = step_q;
    ovalid_d  = ovalid_q && !out_m.ready;
    ofilt_d   = ofilt_q;
    oend_d    = oend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          in_cnt_d = cnt_next;
          if (emit) begin
            addr_d  = out_pos_q[AW-1:0] - lag[AW-1:0];
            ci_d    = '0;
            cj_d    = '0;
            sum_d   = '0;
            cnt_d   = '0;
            state_d = ST_CRD;
          end
        end
      end
      ST_CRD: begin
        state_d = ST_CLAT;
      end
      ST_CLAT, ST_SCAN: begin
        if (state_q == ST_CLAT) begin
          centre_d = rdata;
        end else if (pend_q && diff < sigma_q) begin
          sum_d = sum_q + swf_pkg::SUM_W'(rdata);
          cnt_d = cnt_q + swf_pkg::CNT_W'(1);
        end
        pend_d = cell_ok;
        if (last_col) begin
          cj_d   = '0;
          ci_d   = ci_q + 3'd1;
          addr_d = addr_q + AW'(eff_w) - AW'({half, 1'b0});
        end else begin
          cj_d   = cj_q + 3'd1;
          addr_d = addr_q + AW'(1);
        end
        state_d = last_cell ? ST_TAIL : ST_SCAN;
      end
      ST_TAIL: begin
        if (pend_q && diff < sigma_q) begin
          sum_d = sum_q + swf_pkg::SUM_W'(rdata);
          cnt_d = cnt_q + swf_pkg::CNT_W'(1);
        end
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (trial_ge) begin
          rem_d = trial_sub[swf_pkg::CNT_W-1:0];
        end else begin
          rem_d = trial[swf_pkg::CNT_W-1:0];
        end
        sum_d  = {sum_q[swf_pkg::SUM_W-2:0], trial_ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'(swf_pkg::SUM_W - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ofilt_d  = (cnt_q == '0) ? centre_q : sum_q[swf_pkg::PIX_W-1:0];
          oend_d   = pos_last;
          if (pos_last) begin
            in_cnt_d  = '0;
            out_pos_d = '0;
            out_row_d = '0;
            out_col_d = '0;
          end else begin
            out_pos_d = out_pos_q + PW'(1);
            if (out_col_q + DW'(1) == eff_w) begin
              out_col_d = '0;
              out_row_d = out_row_q + DW'(1);
            end else begin
              out_col_d = out_col_q + DW'(1);
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A register write restarts the frame.
    if (cfg_we_i) begin
      in_cnt_d  = '0;
      out_pos_d = '0;
      out_row_d = '0;
      out_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_cnt_q  <= '0;
      out_pos_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      pend_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      win_q     <= swf_pkg::RST_WINDOW_SIZE;
      sigma_q   <= swf_pkg::RST_SIGMA_LIMIT;
      fw_q      <= swf_pkg::RST_FRAME_WIDTH;
      fh_q      <= swf_pkg::RST_FRAME_HEIGHT;
    end else begin
      state_q   <= state_d;
      in_cnt_q  <= in_cnt_d;
      out_pos_q <= out_pos_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      pend_q    <= pend_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i) begin
        unique case (swf_pkg::cfg_reg_e'(cfg_idx_i))
          swf_pkg::REG_WINDOW_SIZE:  win_q   <= cfg_data_i[2:0];
          swf_pkg::REG_SIGMA_LIMIT:  sigma_q <= cfg_data_i[swf_pkg::PIX_W-1:0];
          swf_pkg::REG_FRAME_WIDTH:  fw_q    <= cfg_data_i;
          swf_pkg::REG_FRAME_HEIGHT: fh_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    ci_q     <= ci_d;
    cj_q     <= cj_d;
    centre_q <= centre_d;
    sum_q    <= sum_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    ofilt_q  <= ofilt_d;
    oend_q   <= oend_d;
  end

  assign out_m.valid     = ovalid_q;
  assign out_m.filtered  = ofilt_q;
  assign out_m.frame_end = oend_q;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Sigma window filter testbench
// Feeds whole frames of random pixels through the filter under many window,
// threshold and frame size settings, predicts every filtered pixel and checks
// each output beat against the prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic                      kind;
    logic [swf_pkg::PIX_W-1:0] sample;
  } pix_beat_t;

  typedef struct packed {
    logic [swf_pkg::PIX_W-1:0] filtered;
    logic                      frame_end;
  } filt_pix_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_GAP   = 150;
  localparam int unsigned RANDOM_BEATS = 1250;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [swf_pkg::CFG_AW-1:0]   cfg_idx_i;
  logic [swf_pkg::CFG_DW-1:0]   cfg_data_i;

  swf_in_if  pix_in ();
  swf_out_if pix_out ();

  sigma_window_filter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (pix_in.sink),
    .out_m      (pix_out.source)
  );

  // Beats waiting to be driven, and filtered pixels still owed by the block.
  pix_beat_t beat_q[$];
  filt_pix_t filt_q[$];

  // Mirror of the block's registers and raster state.
  logic [2:0]                win_reg;
  logic [swf_pkg::PIX_W-1:0] sigma_reg;
  logic [swf_pkg::DIM_W-1:0] width_reg;
  logic [swf_pkg::DIM_W-1:0] height_reg;
  logic [swf_pkg::PIX_W-1:0] frame_px [0:swf_pkg::MAX_LINE*swf_pkg::MAX_HEIGHT-1];
  int unsigned               pix_count;
  int unsigned               out_pos;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned beats_sent;
  int unsigned cycles;
  int unsigned phases;

  // Effective sizes after the block's own clamping.
  function automatic int unsigned eff_w();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > swf_pkg::MAX_LINE) w = swf_pkg::MAX_LINE;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > swf_pkg::MAX_HEIGHT) h = swf_pkg::MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned half_win();
    int unsigned h;
    h = win_reg >> 1;
    if (h > swf_pkg::MAX_WINDOW / 2) h = swf_pkg::MAX_WINDOW / 2;
    return h;
  endfunction

  // Sigma-gated mean of the window around one raster position. Neighbours
  // outside the frame are skipped and the centre counts as its own neighbour.
  function automatic logic [swf_pkg::PIX_W-1:0] sigma_mean(int unsigned pos);
    int w, hgt, hw, r, c, rr, cc, v, d, centre;
    int unsigned sum, num;
    w = eff_w();
    hgt = eff_h();
    hw = half_win();
    r = pos / w;
    c = pos % w;
    centre = frame_px[pos];
    sum = 0;
    num = 0;
    for (int di = -hw; di <= hw; di++) begin
      for (int dj = -hw; dj <= hw; dj++) begin
        rr = r + di;
        cc = c + dj;
        if (rr >= 0 && rr < hgt && cc >= 0 && cc < w) begin
          v = frame_px[rr * w + cc];
          d = (v > centre) ? v - centre : centre - v;
          if (d < sigma_reg) begin
            sum += v;
            num++;
          end
        end
      end
    end
    if (num == 0) return centre[swf_pkg::PIX_W-1:0];
    return swf_pkg::PIX_W'(sum / num);
  endfunction

  // Advances the raster state by one accepted beat and queues the filtered
  // pixel it releases, if any.
  function automatic void predict_beat(pix_beat_t b);
    int unsigned total, lag, need;
    filt_pix_t   res;
    total = eff_w() * eff_h();
    lag = half_win() * eff_w() + half_win();
    if (!b.kind && pix_count < total) begin
      frame_px[pix_count] = b.sample;
      pix_count++;
    end
    if (out_pos >= total) return;
    need = out_pos + lag + 1;
    if (need > total) need = total;
    if (pix_count < need) return;
    res.filtered = sigma_mean(out_pos);
    out_pos++;
    res.frame_end = (out_pos == total);
    if (res.frame_end) begin
      pix_count = 0;
      out_pos = 0;
    end
    filt_q.push_back(res);
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: holds a beat until it is taken, then maybe idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in.valid  <= 1'b0;
      pix_in.kind   <= 1'b0;
      pix_in.sample <= '0;
    end else begin
      logic      busy;
      pix_beat_t nb;
      busy = pix_in.valid;
      if (pix_in.valid && pix_in.ready) begin
        predict_beat(pix_beat_t'{kind: pix_in.kind, sample: pix_in.sample});
        beats_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = beat_q.pop_front();
          pix_in.valid  <= 1'b1;
          pix_in.kind   <= nb.kind;
          pix_in.sample <= nb.sample;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output beat against the oldest predicted pixel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      filt_pix_t want;
      if (pix_out.valid && pix_out.ready) begin
        checked++;
        if (filt_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected output beat filtered=%0d frame_end=%0b",
                     pix_out.filtered, pix_out.frame_end);
        end else begin
          want = filt_q.pop_front();
          if (want.filtered !== pix_out.filtered ||
              want.frame_end !== pix_out.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: output %0d expected filtered=%0d frame_end=%0b, got %0d/%0b",
                       checked, want.filtered, want.frame_end,
                       pix_out.filtered, pix_out.frame_end);
          end
        end
      end
      pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Writes one register; the frame restarts in the block and in the mirror.
  task automatic write_reg(swf_pkg::cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= swf_pkg::CFG_DW'(val);
    case (idx)
      swf_pkg::REG_WINDOW_SIZE:  win_reg = 3'(val);
      swf_pkg::REG_SIGMA_LIMIT:  sigma_reg = swf_pkg::PIX_W'(val);
      swf_pkg::REG_FRAME_WIDTH:  width_reg = swf_pkg::DIM_W'(val);
      swf_pkg::REG_FRAME_HEIGHT: height_reg = swf_pkg::DIM_W'(val);
      default: ;
    endcase
    pix_count = 0;
    out_pos = 0;
  endtask

  // Sets all four registers and picks how both sides idle in this phase.
  task automatic set_phase(int unsigned win, int unsigned sig, int unsigned w,
                           int unsigned h);
    write_reg(swf_pkg::REG_WINDOW_SIZE, win);
    write_reg(swf_pkg::REG_SIGMA_LIMIT, sig);
    write_reg(swf_pkg::REG_FRAME_WIDTH, w);
    write_reg(swf_pkg::REG_FRAME_HEIGHT, h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (phases % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
    phases++;
  endtask

  // Waits until every beat is taken and every pixel checked, then lets the
  // block settle before the registers may be touched again.
  task automatic drain();
    while (beat_q.size() != 0 || pix_in.valid || filt_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Queues one whole frame followed by the flush beats that empty it. A few
  // of those flushes are pixel beats, which the block treats as flushes once
  // the frame is complete; stray flushes mid-frame and at the end release
  // nothing.
  task automatic queue_frame(bit noisy);
    int unsigned total, lag, owed;
    pix_beat_t   b;
    total = eff_w() * eff_h();
    lag = half_win() * eff_w() + half_win();
    owed = (lag < total - 1) ? lag : total - 1;
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        b.kind = 1'b1;
        b.sample = swf_pkg::PIX_W'($urandom);
        beat_q.push_back(b);
      end
      b.kind = 1'b0;
      // Mostly smooth content with occasional outliers, so sigma gating bites.
      if ($urandom_range(3) == 0) b.sample = swf_pkg::PIX_W'($urandom);
      else b.sample = swf_pkg::PIX_W'(100 + $urandom_range(40));
      beat_q.push_back(b);
    end
    for (int unsigned i = 0; i < owed; i++) begin
      b.kind = noisy ? ($urandom_range(7) != 0) : 1'b1;
      b.sample = swf_pkg::PIX_W'($urandom);
      beat_q.push_back(b);
    end
    if (noisy) begin
      repeat ($urandom_range(2)) begin
        b.kind = 1'b1;
        b.sample = swf_pkg::PIX_W'($urandom);
        beat_q.push_back(b);
      end
    end
  endtask

  initial begin
    pix_beat_t b;
    int unsigned frames;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = swf_pkg::REG_WINDOW_SIZE;
    cfg_data_i = '0;
    win_reg = swf_pkg::RST_WINDOW_SIZE;
    sigma_reg = swf_pkg::RST_SIGMA_LIMIT;
    width_reg = swf_pkg::RST_FRAME_WIDTH;
    height_reg = swf_pkg::RST_FRAME_HEIGHT;
    pix_count = 0;
    out_pos = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    checked = 0;
    beats_sent = 0;
    cycles = 0;
    phases = 0;
    frames = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 4x3 frame with extreme samples and a flush before any
    // output is ready, then a one-pixel frame with zero sigma and zero sizes.
    set_phase(3, 255, 4, 3);
    b.kind = 1'b1;
    b.sample = 8'hFF;
    beat_q.push_back(b);
    for (int i = 0; i < 12; i++) begin
      b.kind = 1'b0;
      b.sample = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'h80;
      beat_q.push_back(b);
    end
    // Pending outputs: one pixel beat acting as a flush, then plain flushes.
    b.kind = 1'b0;
    b.sample = 8'h55;
    beat_q.push_back(b);
    b.kind = 1'b1;
    b.sample = 8'h00;
    repeat (5) beat_q.push_back(b);
    drain();
    set_phase(7, 0, 0, 0);
    b.kind = 1'b0;
    b.sample = 8'hAA;
    beat_q.push_back(b);
    b.kind = 1'b1;
    beat_q.push_back(b);
    drain();

    // Random settings, mostly small frames, a frame or two per phase.
    while (beats_sent < RANDOM_BEATS) begin
      set_phase($urandom_range(7),
                ($urandom_range(4) == 0) ? $urandom_range(1) * 255 : $urandom_range(255),
                $urandom_range(12), $urandom_range(9));
      repeat (1 + $urandom_range(1)) begin
        queue_frame($urandom_range(2) == 0);
        frames++;
      end
      drain();
    end

    $display("Checked %0d filtered pixels from %0d input beats over %0d register phases",
             checked, beats_sent, phases);
    $display("and %0d random frames, with windows up to 7x7 and both sides idling.",
             frames);
    if (mismatches == 0 && filt_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d outputs missing", mismatches, filt_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/swf_pkg.sv
hw/rtl/swf_in_if.sv
hw/rtl/swf_out_if.sv
hw/rtl/swf_ram.sv
hw/rtl/sigma_window_filter_unit.sv
tb/sv/testbench.sv
